### rtl/asu_pkg.sv
// Shared types, register indexes and reset values of the arrive steering unit.
package asu_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CFG_W-1:0]          cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  localparam cfg_idx_t REG_MAX_SPEED      = 3'd0;
  localparam cfg_idx_t REG_MAX_ACCEL      = 3'd1;
  localparam cfg_idx_t REG_ARRIVE_RADIUS  = 3'd2;
  localparam cfg_idx_t REG_SLOW_RADIUS    = 3'd3;
  localparam cfg_idx_t REG_TIME_TO_TARGET = 3'd4;

  localparam cfg_word_t RST_MAX_SPEED      = 31'd131072;
  localparam cfg_word_t RST_MAX_ACCEL      = 31'd655360;
  localparam cfg_word_t RST_ARRIVE_RADIUS  = 31'd262144;
  localparam cfg_word_t RST_SLOW_RADIUS    = 31'd2097152;
  localparam cfg_word_t RST_TIME_TO_TARGET = 31'd65536;

endpackage

### rtl/asu_in_if.sv
// Input channel of the arrive steering unit: positions and velocity of one mover.
interface asu_in_if;
  import asu_pkg::*;

  logic   valid;
  logic   ready;
  coord_t target_x;
  coord_t target_y;
  coord_t mover_x;
  coord_t mover_y;
  coord_t vel_x;
  coord_t vel_y;

  modport source (output valid, output target_x, output target_y, output mover_x,
                  output mover_y, output vel_x, output vel_y, input ready);
  modport sink (input valid, input target_x, input target_y, input mover_x,
                input mover_y, input vel_x, input vel_y, output ready);
endinterface

### rtl/asu_out_if.sv
// Output channel of the arrive steering unit: one steering acceleration per beat.
interface asu_out_if;
  import asu_pkg::*;

  logic   valid;
  logic   ready;
  coord_t accel_x;
  coord_t accel_y;
  logic   clamped;

  modport source (output valid, output accel_x, output accel_y, output clamped, input ready);
  modport sink (input valid, input accel_x, input accel_y, input clamped, output ready);
endinterface

### rtl/arrive_steering_unit.sv
// Top level of the arrive steering unit: configuration registers and the full datapath.
// Takes one mover per cycle while the output is not stalled, and returns one steering
// acceleration per mover, in order. The datapath holds two pipelined square roots and
// four pipelined dividers, each one stage per result bit; the offset length
// root is 33 stages, the speed and desired velocity dividers 31 each, the division by
// time_to_target 33 + FRAC_BITS, the magnitude root 34 + FRAC_BITS and the rescaling
// divider 31. The whole pipeline holds while a result waits at the output, so a stall
// costs no throughput beyond the stalled cycles. Registers may only be written while
// the pipeline is empty.
module arrive_steering_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  asu_pkg::cfg_idx_t cfg_index,
  input  asu_pkg::cfg_word_t cfg_data,
  asu_in_if.sink            in_ch,
  asu_out_if.source         out_ch
);
  import asu_pkg::*;

  localparam int OFFW = COORD_W + 1;           // offset magnitude and its length
  localparam int DSQW = 2 * OFFW;
  localparam int AW   = OFFW + FRAC_BITS;      // acceleration magnitude before clamp
  localparam int H    = (AW + 1) / 2;
  localparam int HW   = AW - H;
  localparam int SQW  = 2 * AW;
  localparam int SUMW = SQW + 1;
  localparam int MW   = AW + 1;
  localparam int RNW  = AW + CFG_W;

  typedef struct packed {
    logic [OFFW-1:0] mdx;
    logic [OFFW-1:0] mdy;
    logic            negx;
    logic            negy;
    coord_t          vx;
    coord_t          vy;
  } off_t;

  typedef struct packed {
    off_t            off;
    logic [OFFW-1:0] span;
    logic            dist_zero;
    logic            lt_arrive;
    logic            gt_slow;
    logic            slow_zero;
  } spd_side_t;

  typedef struct packed {
    logic   negx;
    logic   negy;
    logic   dist_zero;
    coord_t vx;
    coord_t vy;
  } vel_side_t;

  typedef struct packed {
    logic [AW-1:0] axm;
    logic [AW-1:0] aym;
    logic          negx;
    logic          negy;
  } mag_t;

  typedef struct packed {
    mag_t m;
    logic clamp;
  } acc_side_t;

  // Configuration registers.
  cfg_word_t max_speed, max_accel, arrive_radius, slow_radius, time_to_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed      <= RST_MAX_SPEED;
      max_accel      <= RST_MAX_ACCEL;
      arrive_radius  <= RST_ARRIVE_RADIUS;
      slow_radius    <= RST_SLOW_RADIUS;
      time_to_target <= RST_TIME_TO_TARGET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_SPEED:      max_speed      <= cfg_data;
        REG_MAX_ACCEL:      max_accel      <= cfg_data;
        REG_ARRIVE_RADIUS:  arrive_radius  <= cfg_data;
        REG_SLOW_RADIUS:    slow_radius    <= cfg_data;
        REG_TIME_TO_TARGET: time_to_target <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [OFFW:0] offset(coord_t a, coord_t b);
    logic signed [OFFW-1:0] d;
    d = OFFW'(a) - OFFW'(b);
    return {d[OFFW-1], (d[OFFW-1] ? (OFFW'(0) - d) : d)};
  endfunction

  // Signed desired component minus velocity, returned as sign and magnitude.
  function automatic logic [OFFW:0] vel_diff(logic neg, logic zero, logic [CFG_W-1:0] q,
                                             coord_t v);
    logic [CFG_W-1:0]       wm;
    logic signed [OFFW-1:0] w;
    logic signed [OFFW-1:0] f;
    wm = zero ? '0 : q;
    w  = neg ? (OFFW'(0) - OFFW'(wm)) : OFFW'(wm);
    f  = w - OFFW'(v);
    return {f[OFFW-1], (f[OFFW-1] ? (OFFW'(0) - f) : f)};
  endfunction

  function automatic coord_t signed_out(logic neg, logic clamp, logic [CFG_W-1:0] q,
                                        logic [AW-1:0] am);
    logic [COORD_W-1:0] m;
    if (clamp) begin
      m = COORD_W'(q);
    end else if (|am[AW-1:CFG_W]) begin
      // The negative range reaches one step further than the positive one.
      m = neg ? {1'b1, {CFG_W{1'b0}}} : {1'b0, {CFG_W{1'b1}}};
    end else begin
      m = COORD_W'(am[CFG_W-1:0]);
    end
    return neg ? (COORD_W'(0) - m) : m;
  endfunction

  logic adv;
  logic out_valid;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Offset, its squares and their sum.
  logic [OFFW:0] c0_dx, c0_dy;
  assign c0_dx = offset(in_ch.target_x, in_ch.mover_x);
  assign c0_dy = offset(in_ch.target_y, in_ch.mover_y);

  logic            s0_vld, s1_vld, s2_vld;
  off_t            s0_off, s1_off, s2_off;
  logic [DSQW-1:0] s1_sqx, s1_sqy, s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_ch.valid;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
    end
    if (adv) begin
      s0_off.negx <= c0_dx[OFFW];
      s0_off.mdx  <= c0_dx[OFFW-1:0];
      s0_off.negy <= c0_dy[OFFW];
      s0_off.mdy  <= c0_dy[OFFW-1:0];
      s0_off.vx   <= in_ch.vel_x;
      s0_off.vy   <= in_ch.vel_y;
      s1_sqx      <= s0_off.mdx * s0_off.mdx;
      s1_sqy      <= s0_off.mdy * s0_off.mdy;
      s1_off      <= s0_off;
      s2_sum      <= s1_sqx + s1_sqy;
      s2_off      <= s1_off;
    end
  end

  logic            d_vld;
  logic [OFFW-1:0] d_root;
  off_t            d_off;

  asu_sqrt #(.RW(OFFW), .SW($bits(off_t))) u_dist_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s2_vld), .rad(s2_sum), .in_side(s2_off),
    .out_valid(d_vld), .root(d_root), .out_side(d_off)
  );

  // Speed zone and the linear zone product.
  logic                     s3_vld;
  logic [0:0][2*CFG_W-1:0]  s3_prod;
  spd_side_t                s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= d_vld;
    end
    if (adv) begin
      s3_prod[0]        <= max_speed * d_root[CFG_W-1:0];
      s3_side.off       <= d_off;
      s3_side.span      <= d_root;
      s3_side.dist_zero <= (d_root == '0);
      s3_side.lt_arrive <= (d_root < OFFW'(arrive_radius));
      s3_side.gt_slow   <= (d_root > OFFW'(slow_radius));
      s3_side.slow_zero <= (slow_radius == '0);
    end
  end

  logic                 sp_vld;
  logic [0:0][CFG_W-1:0] sp_q;
  spd_side_t            sp_side;

  asu_div #(.NL(1), .NW(2*CFG_W), .DW(CFG_W), .QW(CFG_W), .SW($bits(spd_side_t))) u_speed_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s3_vld), .num(s3_prod), .den(slow_radius),
    .in_side(s3_side), .out_valid(sp_vld), .quot(sp_q), .out_side(sp_side)
  );

  // Desired speed, then the offset scaled by it.
  logic                 s4_vld, s5_vld;
  logic [CFG_W-1:0]     s4_speed;
  spd_side_t            s4_side;
  logic [1:0][2*OFFW-2:0] s5_num;
  logic [OFFW-1:0]      s5_dist;
  vel_side_t            s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= sp_vld;
      s5_vld <= s4_vld;
    end
    if (adv) begin
      // The arrive radius test comes first.
      if (sp_side.lt_arrive) begin
        s4_speed <= '0;
      end else if (sp_side.gt_slow) begin
        s4_speed <= max_speed;
      end else if (sp_side.slow_zero) begin
        s4_speed <= '0;
      end else begin
        s4_speed <= sp_q[0];
      end
      s4_side <= sp_side;
      s5_num[0]         <= s4_side.off.mdx * s4_speed;
      s5_num[1]         <= s4_side.off.mdy * s4_speed;
      s5_dist           <= s4_side.span;
      s5_side.negx      <= s4_side.off.negx;
      s5_side.negy      <= s4_side.off.negy;
      s5_side.dist_zero <= s4_side.dist_zero;
      s5_side.vx        <= s4_side.off.vx;
      s5_side.vy        <= s4_side.off.vy;
    end
  end

  logic                  w_vld;
  logic [1:0][CFG_W-1:0] w_q;
  vel_side_t             w_side;

  asu_div #(.NL(2), .NW(2*OFFW-1), .DW(OFFW), .QW(CFG_W), .SW($bits(vel_side_t))) u_desire_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s5_vld), .num(s5_num), .den(s5_dist),
    .in_side(s5_side), .out_valid(w_vld), .quot(w_q), .out_side(w_side)
  );

  // Velocity difference, scaled up for the division by time to target.
  logic [OFFW:0] c6_fx, c6_fy;
  assign c6_fx = vel_diff(w_side.negx, w_side.dist_zero, w_q[0], w_side.vx);
  assign c6_fy = vel_diff(w_side.negy, w_side.dist_zero, w_q[1], w_side.vy);

  cfg_word_t ttt_eff;
  assign ttt_eff = (time_to_target == '0) ? CFG_W'(1) : time_to_target;

  logic               s6_vld;
  logic [1:0][AW-1:0] s6_num;
  logic [1:0]         s6_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= w_vld;
    end
    if (adv) begin
      s6_num[0] <= {c6_fx[OFFW-1:0], {FRAC_BITS{1'b0}}};
      s6_num[1] <= {c6_fy[OFFW-1:0], {FRAC_BITS{1'b0}}};
      s6_neg    <= {c6_fy[OFFW], c6_fx[OFFW]};
    end
  end

  logic               a_vld;
  logic [1:0][AW-1:0] a_q;
  logic [1:0]         a_neg;

  asu_div #(.NL(2), .NW(AW), .DW(CFG_W), .QW(AW), .SW(2)) u_time_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s6_vld), .num(s6_num), .den(ttt_eff),
    .in_side(s6_neg), .out_valid(a_vld), .quot(a_q), .out_side(a_neg)
  );

  // Squared magnitude from half-width partial products, then the clamp test.
  logic                s7_vld, s8_vld, s9_vld, s10_vld;
  mag_t                s7_m, s8_m, s9_m, s10_m;
  logic [2*HW-1:0]     s7_xhh, s7_yhh;
  logic [HW+H-1:0]     s7_xhl, s7_yhl;
  logic [2*H-1:0]      s7_xll, s7_yll;
  logic [2*CFG_W-1:0]  s7_mm, s8_mm, s9_mm;
  logic [SQW-1:0]      s8_sqx, s8_sqy;
  logic [SUMW-1:0]     s9_sum, s10_sum;
  logic                s10_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
    end else if (adv) begin
      s7_vld  <= a_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= s8_vld;
      s10_vld <= s9_vld;
    end
    if (adv) begin
      s7_m.axm <= a_q[0];
      s7_m.aym <= a_q[1];
      s7_m.negx <= a_neg[0];
      s7_m.negy <= a_neg[1];
      s7_xhh <= a_q[0][AW-1:H] * a_q[0][AW-1:H];
      s7_xhl <= a_q[0][AW-1:H] * a_q[0][H-1:0];
      s7_xll <= a_q[0][H-1:0] * a_q[0][H-1:0];
      s7_yhh <= a_q[1][AW-1:H] * a_q[1][AW-1:H];
      s7_yhl <= a_q[1][AW-1:H] * a_q[1][H-1:0];
      s7_yll <= a_q[1][H-1:0] * a_q[1][H-1:0];
      s7_mm  <= max_accel * max_accel;

      s8_m   <= s7_m;
      s8_mm  <= s7_mm;
      s8_sqx <= (SQW'(s7_xhh) << (2 * H)) + (SQW'(s7_xhl) << (H + 1)) + SQW'(s7_xll);
      s8_sqy <= (SQW'(s7_yhh) << (2 * H)) + (SQW'(s7_yhl) << (H + 1)) + SQW'(s7_yll);

      s9_m   <= s8_m;
      s9_mm  <= s8_mm;
      s9_sum <= SUMW'(s8_sqx) + SUMW'(s8_sqy);

      s10_m     <= s9_m;
      s10_sum   <= s9_sum;
      s10_clamp <= (s9_sum > SUMW'(s9_mm));
    end
  end

  acc_side_t c10_side;
  assign c10_side.m     = s10_m;
  assign c10_side.clamp = s10_clamp;

  logic          m_vld;
  logic [MW-1:0] m_root;
  acc_side_t     m_side;

  asu_sqrt #(.RW(MW), .SW($bits(acc_side_t))) u_mag_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s10_vld), .rad((2*MW)'(s10_sum)),
    .in_side(c10_side), .out_valid(m_vld), .root(m_root), .out_side(m_side)
  );

  // Components times max_accel, ready for division by the magnitude.
  logic                s11_vld, s12_vld;
  acc_side_t           s11_side, s12_side;
  logic [MW-1:0]       s11_m, s12_m;
  logic [HW+CFG_W-1:0] s11_xph, s11_yph;
  logic [H+CFG_W-1:0]  s11_xpl, s11_ypl;
  logic [1:0][RNW-1:0] s12_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_vld <= 1'b0;
      s12_vld <= 1'b0;
    end else if (adv) begin
      s11_vld <= m_vld;
      s12_vld <= s11_vld;
    end
    if (adv) begin
      s11_side <= m_side;
      s11_m    <= m_root;
      s11_xph  <= m_side.m.axm[AW-1:H] * max_accel;
      s11_xpl  <= m_side.m.axm[H-1:0] * max_accel;
      s11_yph  <= m_side.m.aym[AW-1:H] * max_accel;
      s11_ypl  <= m_side.m.aym[H-1:0] * max_accel;

      s12_side   <= s11_side;
      s12_m      <= s11_m;
      s12_num[0] <= (RNW'(s11_xph) << H) + RNW'(s11_xpl);
      s12_num[1] <= (RNW'(s11_yph) << H) + RNW'(s11_ypl);
    end
  end

  logic                  r_vld;
  logic [1:0][CFG_W-1:0] r_q;
  acc_side_t             r_side;

  asu_div #(.NL(2), .NW(RNW), .DW(MW), .QW(CFG_W), .SW($bits(acc_side_t))) u_scale_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s12_vld), .num(s12_num), .den(s12_m),
    .in_side(s12_side), .out_valid(r_vld), .quot(r_q), .out_side(r_side)
  );

  // Output register: a finished beat waits here while the pipeline holds.
  coord_t out_x, out_y;
  logic   out_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= r_vld;
    end
    if (adv) begin
      out_x     <= signed_out(r_side.m.negx, r_side.clamp, r_q[0], r_side.m.axm);
      out_y     <= signed_out(r_side.m.negy, r_side.clamp, r_q[1], r_side.m.aym);
      out_clamp <= r_side.clamp;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.accel_x = out_x;
  assign out_ch.accel_y = out_y;
  assign out_ch.clamped = out_clamp;

endmodule

### rtl/asu_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband carried alongside.
module asu_sqrt #(
  parameter int RW = 33,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   out_side
);

  logic            vld   [RW];
  logic [RW+1:0]   rem   [RW];
  logic [RW-1:0]   rt    [RW];
  logic [2*RW-1:0] rsh   [RW];
  logic [SW-1:0]   side  [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic            v_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   rt_in;
    logic [2*RW-1:0] rsh_in;
    logic [SW-1:0]   side_in;
    logic [RW+3:0]   acc;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign rt_in   = '0;
      assign rsh_in  = rad;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[g-1];
      assign rem_in  = rem[g-1];
      assign rt_in   = rt[g-1];
      assign rsh_in  = rsh[g-1];
      assign side_in = side[g-1];
    end

    // Bring down the next two radicand bits and try the root bit as one.
    assign acc   = {rem_in, rsh_in[2*RW-1 -: 2]};
    assign trial = {2'b00, rt_in, 2'b01};
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_in;
      end
      if (en) begin
        if (acc >= trial) begin
          rem[g] <= diff[RW+1:0];
          rt[g]  <= {rt_in[RW-2:0], 1'b1};
        end else begin
          rem[g] <= acc[RW+1:0];
          rt[g]  <= {rt_in[RW-2:0], 1'b0};
        end
        rsh[g]  <= {rsh_in[2*RW-3:0], 2'b00};
        side[g] <= side_in;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign out_side  = side[RW-1];

endmodule

### rtl/asu_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
module asu_div #(
  parameter int NL = 1,
  parameter int NW = 62,
  parameter int DW = 31,
  parameter int QW = 31,
  parameter int SW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [NL-1:0][NW-1:0]  num,
  input  logic [DW-1:0]          den,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic [NL-1:0][QW-1:0]  quot,
  output logic [SW-1:0]          out_side
);

  localparam int EW = QW + DW;

  logic [NL-1:0][EW-1:0] ext;
  logic [NL-1:0][DW-1:0] rem0;
  logic [NL-1:0][QW-1:0] lo0;

  logic                  vld  [QW];
  logic [DW-1:0]         dsr  [QW];
  logic [NL-1:0][DW-1:0] rem  [QW];
  logic [NL-1:0][QW-1:0] lo   [QW];
  logic [SW-1:0]         side [QW];

  // The quotient is known to fit QW bits, so the top of the dividend starts as remainder.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      ext[l]  = EW'(num[l]);
      rem0[l] = ext[l][EW-1:QW];
      lo0[l]  = ext[l][QW-1:0];
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic                  v_in;
    logic [DW-1:0]         d_in;
    logic [NL-1:0][DW-1:0] rem_in;
    logic [NL-1:0][QW-1:0] lo_in;
    logic [SW-1:0]         side_in;
    logic [NL-1:0][DW:0]   acc;
    logic [NL-1:0][DW:0]   diff;
    logic [NL-1:0][DW-1:0] rem_next;
    logic [NL-1:0][QW-1:0] lo_next;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign d_in    = den;
      assign rem_in  = rem0;
      assign lo_in   = lo0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[g-1];
      assign d_in    = dsr[g-1];
      assign rem_in  = rem[g-1];
      assign lo_in   = lo[g-1];
      assign side_in = side[g-1];
    end

    // Dividend bits shift out of the low word as quotient bits shift in.
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        acc[l]  = {rem_in[l], lo_in[l][QW-1]};
        diff[l] = acc[l] - {1'b0, d_in};
        if (acc[l] >= {1'b0, d_in}) begin
          rem_next[l] = diff[l][DW-1:0];
          lo_next[l]  = {lo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_next[l] = acc[l][DW-1:0];
          lo_next[l]  = {lo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_in;
      end
      if (en) begin
        dsr[g]  <= d_in;
        rem[g]  <= rem_next;
        lo[g]   <= lo_next;
        side[g] <= side_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = lo[QW-1];
  assign out_side  = side[QW-1];

endmodule

### dv/arrive_steering_unit_test.sv
// Self-checking testbench of the arrive steering unit: directed table, special register settings, then random movers.
`timescale 1ns / 1ps

module arrive_steering_unit_test;
  import asu_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = 207 + 2 * FRAC_BITS;
  localparam int N_RANDOM  = 1630;

  typedef struct {
    coord_t target_x, target_y, mover_x, mover_y, vel_x, vel_y;
  } mover_t;

  typedef struct {
    coord_t accel_x, accel_y;
    logic   clamped;
  } steer_t;

  typedef struct {
    mover_t m;
    logic   known;
    steer_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  cfg_word_t cfg_data;

  asu_in_if  in_ch ();
  asu_out_if out_ch ();

  arrive_steering_unit #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  // Register shadow used by the predictor.
  cfg_word_t max_speed, max_accel, arrive_radius, slow_radius, time_to_target;

  steer_t pending_accel[$];
  steer_t typed_accel[$];
  logic   typed_known[$];
  int     errors = 0;
  int     beats_checked = 0;
  int     phases = 0;
  bit     steady = 1'b0;

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic coord_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic steer_t arrive_accel(input mover_t m);
    logic signed [63:0] dx, dy, wx, wy, fx, fy, ax, ay;
    logic [63:0] mdx, mdy, span, speed, ttt, axm, aym, mm;
    logic [127:0] sum, lim;
    steer_t r;
    dx = m.target_x - m.mover_x;
    dy = m.target_y - m.mover_y;
    mdx = magnitude(dx);
    mdy = magnitude(dy);
    span = isqrt(128'(mdx) * 128'(mdx) + 128'(mdy) * 128'(mdy));
    // The arrive radius wins when the two radii are crossed.
    if (span < 64'(arrive_radius)) speed = 0;
    else if (span > 64'(slow_radius)) speed = 64'(max_speed);
    else if (slow_radius == 0) speed = 0;
    else speed = (64'(max_speed) * span) / 64'(slow_radius);
    wx = 0;
    wy = 0;
    if (span != 0) begin
      wx = (mdx * speed) / span;
      wy = (mdy * speed) / span;
      if (dx < 0) wx = -wx;
      if (dy < 0) wy = -wy;
    end
    fx = wx - m.vel_x;
    fy = wy - m.vel_y;
    ttt = time_to_target != 0 ? 64'(time_to_target) : 64'd1;
    ax = (magnitude(fx) << FRAC_BITS) / ttt;
    ay = (magnitude(fy) << FRAC_BITS) / ttt;
    if (fx < 0) ax = -ax;
    if (fy < 0) ay = -ay;
    axm = magnitude(ax);
    aym = magnitude(ay);
    sum = 128'(axm) * 128'(axm) + 128'(aym) * 128'(aym);
    lim = 128'(max_accel) * 128'(max_accel);
    r.clamped = sum > lim;
    if (r.clamped) begin
      mm = isqrt(sum);
      ax = 64'((128'(axm) * 128'(max_accel)) / 128'(mm));
      ay = 64'((128'(aym) * 128'(max_accel)) / 128'(mm));
      if (fx < 0) ax = -ax;
      if (fy < 0) ay = -ay;
    end
    r.accel_x = sat32(ax);
    r.accel_y = sat32(ay);
    return r;
  endfunction

  // Accepted movers become expectations at the edge that takes them.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      mover_t m;
      m.target_x = in_ch.target_x;
      m.target_y = in_ch.target_y;
      m.mover_x = in_ch.mover_x;
      m.mover_y = in_ch.mover_y;
      m.vel_x = in_ch.vel_x;
      m.vel_y = in_ch.vel_y;
      pending_accel = {pending_accel, arrive_accel(m)};
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      steer_t w;
      logic   k;
      steer_t t;
      if (pending_accel.size() == 0) begin
        $display("%0t: unexpected beat accel=(%0d,%0d) clamped=%0b", $time,
                 out_ch.accel_x, out_ch.accel_y, out_ch.clamped);
        errors++;
      end else begin
        w = pending_accel.pop_front();
        k = 1'b0;
        if (typed_accel.size() != 0) begin
          t = typed_accel.pop_front();
          k = typed_known.pop_front();
        end
        // Rows with a hand-typed answer must agree with both the table and the predictor.
        if (k && (t.accel_x !== w.accel_x || t.accel_y !== w.accel_y ||
                  t.clamped !== w.clamped)) begin
          $display("%0t: table mismatch expected (%0d,%0d,%0b) predicted (%0d,%0d,%0b)",
                   $time, t.accel_x, t.accel_y, t.clamped, w.accel_x, w.accel_y, w.clamped);
          errors++;
        end
        if (k) w = t;
        if (out_ch.accel_x !== w.accel_x) begin
          $display("%0t: accel_x expected %0d actual %0d", $time, w.accel_x, out_ch.accel_x);
          errors++;
        end
        if (out_ch.accel_y !== w.accel_y) begin
          $display("%0t: accel_y expected %0d actual %0d", $time, w.accel_y, out_ch.accel_y);
          errors++;
        end
        if (out_ch.clamped !== w.clamped) begin
          $display("%0t: clamped expected %0b actual %0b", $time, w.clamped, out_ch.clamped);
          errors++;
        end
        beats_checked++;
      end
    end
  end

  // Receiver stalls with a chance of 29 in a hundred except during the steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 29);
  end

  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_MAX_SPEED:      max_speed = val;
      REG_MAX_ACCEL:      max_accel = val;
      REG_ARRIVE_RADIUS:  arrive_radius = val;
      REG_SLOW_RADIUS:    slow_radius = val;
      REG_TIME_TO_TARGET: time_to_target = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(input cfg_word_t spd, input cfg_word_t acc, input cfg_word_t arr,
                           input cfg_word_t slw, input cfg_word_t ttt);
    write_reg(REG_MAX_SPEED, spd);
    write_reg(REG_MAX_ACCEL, acc);
    write_reg(REG_ARRIVE_RADIUS, arr);
    write_reg(REG_SLOW_RADIUS, slw);
    write_reg(REG_TIME_TO_TARGET, ttt);
    cfg_we <= 1'b0;
    phases++;
  endtask

  task automatic send_mover(input mover_t m);
    while (!steady && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.target_x <= m.target_x;
    in_ch.target_y <= m.target_y;
    in_ch.mover_x <= m.mover_x;
    in_ch.mover_y <= m.mover_y;
    in_ch.vel_x <= m.vel_x;
    in_ch.vel_y <= m.vel_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_accel.size() == 0);
    repeat (LATENCY + 40) @(posedge clk);
  endtask

  function automatic coord_t near_coord();
    // Half the time within 64 units of the origin, otherwise anywhere in the coordinate range.
    return $urandom_range(1) ? coord_t'($urandom_range(32'h0080_0000) - 32'h0040_0000)
                             : coord_t'($urandom());
  endfunction

  function automatic cfg_word_t rand_reg();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return cfg_word_t'($urandom_range(32'h0040_0000));
      default: return cfg_word_t'($urandom());
    endcase
  endfunction

  function automatic dir_row_t row(input coord_t tx, input coord_t ty, input coord_t mx,
                                   input coord_t my, input coord_t vx, input coord_t vy,
                                   input logic k, input coord_t ex, input coord_t ey,
                                   input logic ec);
    dir_row_t r;
    r.m = '{tx, ty, mx, my, vx, vy};
    r.known = k;
    r.want = '{ex, ey, ec};
    return r;
  endfunction

  initial begin
    dir_row_t dir_rows[$];
    mover_t m;
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_SPEED;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.mover_x = '0;
    in_ch.mover_y = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    out_ch.ready = 1'b0;
    max_speed = RST_MAX_SPEED;
    max_accel = RST_MAX_ACCEL;
    arrive_radius = RST_ARRIVE_RADIUS;
    slow_radius = RST_SLOW_RADIUS;
    time_to_target = RST_TIME_TO_TARGET;

    // Zero offset and zero velocity, unit velocity, extreme velocities that clamp.
    dir_rows = {dir_rows, row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 32'sh10000, 0, 1, -32'sh10000, 0, 0)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 0, 32'sh10000, 1, 0, -32'sh10000, 0)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 32'sh7fffffff, 0, 1, -32'sh000a0000, 0, 1)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 32'sh80000000, 0, 1, 32'sh000a0000, 0, 1)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 0, 32'sh80000000, 1, 0, 32'sh000a0000, 1)};
    // Inside arrive radius, linear zone, beyond slow radius, exact radius edges.
    dir_rows = {dir_rows, row(32'sh20000, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(32'sh40000, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(32'sh100000, 32'sh80000, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(32'sh200000, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(0, -32'sh300000, 0, 0, 32'sh8000, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(-32'sh123456, 32'sh654321, 32'sh10000, -32'sh20000,
                              -32'sh1234, 32'sh4321, 0, 0, 0, 0)};
    // Offset extremes: widest spans along three diagonals, then tiny offsets.
    dir_rows = {dir_rows, row(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                              0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                              32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(1, 0, 0, 0, 1, 1, 0, 0, 0, 0)};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed_accel = {typed_accel, dir_rows[i].want};
      typed_known = {typed_known, dir_rows[i].known};
      send_mover(dir_rows[i].m);
    end
    drain();

    // Special settings: crossed radii, zero slow radius, zero time, zero and full clamp.
    load_regs(31'h0002_0000, 31'h000a_0000, 31'h0040_0000, 31'h0010_0000, 31'h0001_0000);
    send_mover('{32'sh200000, 0, 0, 0, 0, 0});
    send_mover('{32'sh20_0000, 32'sh30_0000, 0, 0, 32'sh1000, 0});
    drain();
    load_regs(31'h0002_0000, 31'h7fff_ffff, 0, 0, 0);
    send_mover('{0, 0, 0, 0, 0, 0});
    send_mover('{32'sh10000, 0, 0, 0, 1, -1});
    send_mover('{32'sh7fffffff, 0, 32'sh80000000, 0, 0, 0});
    drain();
    load_regs(31'h7fff_ffff, 0, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    send_mover('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 5, -7});
    send_mover('{0, 0, 0, 0, 0, 0});
    send_mover('{0, 0, 0, 0, 32'sh10000, 0});
    drain();
    load_regs(31'h7fff_ffff, 31'h7fff_ffff, 0, 1, 1);
    send_mover('{32'sh7fffffff, 0, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff});
    send_mover('{1, 1, 0, 0, 0, 0});
    drain();

    // Random phases, one of them a stretch with no idling on either side.
    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) load_regs(RST_MAX_SPEED, RST_MAX_ACCEL, RST_ARRIVE_RADIUS,
                             RST_SLOW_RADIUS, RST_TIME_TO_TARGET);
      else load_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
      steady = (ph == 3);
      for (int k = 0; k < N_RANDOM / 8; k++) begin
        if ($urandom_range(3) == 0) begin
          m = '{coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom())};
        end else begin
          m.target_x = near_coord();
          m.target_y = near_coord();
          m.mover_x = m.target_x + coord_t'($urandom_range(32'h0040_0000) - 32'h0020_0000);
          m.mover_y = m.target_y + coord_t'($urandom_range(32'h0040_0000) - 32'h0020_0000);
          m.vel_x = $urandom_range(7) == 0 ? coord_t'($urandom())
                                            : coord_t'($urandom_range(32'h8_0000) - 32'h4_0000);
          m.vel_y = $urandom_range(7) == 0 ? coord_t'($urandom())
                                            : coord_t'($urandom_range(32'h8_0000) - 32'h4_0000);
        end
        send_mover(m);
        n++;
      end
      steady = 1'b0;
      drain();
    end

    $display("Checked %0d steering beats over %0d register settings (%0d random movers).",
             beats_checked, phases + 1, n);
    if (errors == 0 && pending_accel.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending_accel.size());
    $display("FAIL");
    $finish;
  end

endmodule
